### src/ttfa_pkg.sv
package ttfa_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_ALARM = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FIN
  } seq_state_e;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_YELLOW,
    SEG_ORANGE,
    SEG_RED
  } fade_seg_e;

  localparam logic [1:0] CFG_TURN_LEN = 2'd0;
  localparam logic [1:0] CFG_REMIND   = 2'd1;
  localparam logic [1:0] CFG_BEEP_LEN = 2'd2;

  localparam logic [15:0] TURN_LEN_RST = 16'd12000;
  localparam logic [15:0] REMIND_RST   = 16'd6000;
  localparam logic [7:0]  BEEP_LEN_RST = 8'd10;

  localparam logic [7:0] LEVEL_MAX   = 8'd255;
  localparam logic [7:0] GREEN_MID   = 8'd165;
  localparam logic [7:0] MULT_YELLOW = 8'd90;
  localparam logic [7:0] MULT_ORANGE = 8'd165;
  localparam logic [7:0] MULT_RISE   = 8'd255;

  // alarm pattern period is 240 ticks
  localparam logic [7:0] PHASE_LAST = 8'd239;

  // quarter is 14 bits, step multiplier 8 bits
  localparam int QUARTER_W = 14;
  localparam int DIV_W     = QUARTER_W + 8;

  typedef struct packed {
    logic hit;
    logic on;
  } pat_drive_t;

  // on/off slots: 5,5 5,5 10,10 5,5 5,5 10,20, then no override
  function automatic pat_drive_t pattern_drive(logic [7:0] phase);
    pat_drive_t r;
    r.hit = (phase < 8'd90);
    r.on  = (phase < 8'd5) ||
            (phase >= 8'd10 && phase < 8'd15) ||
            (phase >= 8'd20 && phase < 8'd30) ||
            (phase >= 8'd40 && phase < 8'd45) ||
            (phase >= 8'd50 && phase < 8'd55) ||
            (phase >= 8'd60 && phase < 8'd70);
    return r;
  endfunction

endpackage

### src/turn_timer_fade_alarm.sv
// An item passes the setup, division and finish states and is then registered
// to the output when free; only then is a new item taken. The fade quotient
// comes from a restoring divider retiring one quotient bit per cycle (8 steps).
// A new item may be accepted while the previous result waits on the output.
// rst_ni (async, active low) restores register defaults, idle mode,
// red 0 / green 255, and clears all counters and flags.
module turn_timer_fade_alarm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        button_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_level_o,
  output logic [7:0]  green_level_o,
  output logic        buzzer_on_o,
  output logic [1:0]  mode_o
);
  import ttfa_pkg::*;

  // configuration
  logic [15:0] turn_len_q, remind_q;
  logic [7:0]  beep_len_q;

  // sequencer
  seq_state_e state_q, state_d;
  logic [2:0] div_cnt_q;
  logic       commit, div_last;

  // tick state
  mode_e       mode_q, mode_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] alarm_cnt_q, alarm_cnt_d;
  logic [7:0]  phase_q, phase_d;
  logic        prev_q, prev_d;
  logic [7:0]  beep_q, beep_d;
  logic        remind_done_q, remind_done_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;
  logic        buzz_q, buzz_d;
  logic        out_valid_q;

  // payload
  logic             lvl_q;
  fade_seg_e        seg_q;
  logic [DIV_W-1:0] rem_q, dvs_q;
  logic [7:0]       quot_q;

  // setup math
  logic [QUARTER_W-1:0] quarter;
  logic [15:0]          q1, q2, q3, base, diff;
  logic [7:0]           mult;
  fade_seg_e            seg;
  logic [DIV_W-1:0]     prod;
  logic                 trial_ok;

  logic        pressed;
  logic [15:0] el_inc;
  logic [7:0]  fade_red, fade_green;
  pat_drive_t  pat;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_DIV;
      ST_DIV:   if (div_cnt_q == 3'd7) state_d = ST_FIN;
      ST_FIN:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    div_last   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DIV:  div_last = (div_cnt_q == 3'd7);
      ST_FIN:  commit = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // ---------------- fade setup ----------------
  always_comb begin
    quarter = turn_len_q[15:2];
    q1      = {2'b00, quarter};
    q2      = {1'b0, quarter, 1'b0};
    q3      = q2 + q1;
    if (elapsed_q < q1) begin
      seg = SEG_RISE;   base = 16'd0; mult = MULT_RISE;
    end else if (elapsed_q < q2) begin
      seg = SEG_YELLOW; base = q1;    mult = MULT_YELLOW;
    end else if (elapsed_q < q3) begin
      seg = SEG_ORANGE; base = q2;    mult = MULT_ORANGE;
    end else begin
      seg = SEG_RED;    base = elapsed_q; mult = 8'd0;
    end
    diff = elapsed_q - base;
    // diff stays below quarter, so it fits the quarter width
    prod = DIV_W'(diff[QUARTER_W-1:0]) * DIV_W'(mult);
  end

  assign trial_ok = (rem_q >= dvs_q);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      lvl_q <= button_level_i;
    end
    case (state_q)
      ST_SETUP: begin
        seg_q  <= seg;
        rem_q  <= prod;
        dvs_q  <= {1'b0, quarter, 7'd0};
        quot_q <= 8'd0;
      end
      ST_DIV: begin
        if (trial_ok) rem_q <= rem_q - dvs_q;
        quot_q <= {quot_q[6:0], trial_ok};
        dvs_q  <= {1'b0, dvs_q[DIV_W-1:1]};
      end
      default: ;
    endcase
  end

  // ---------------- tick update ----------------
  always_comb begin
    case (seg_q)
      SEG_RISE:   begin fade_red = quot_q;    fade_green = LEVEL_MAX;          end
      SEG_YELLOW: begin fade_red = LEVEL_MAX; fade_green = LEVEL_MAX - quot_q; end
      SEG_ORANGE: begin fade_red = LEVEL_MAX; fade_green = GREEN_MID - quot_q; end
      default:    begin fade_red = LEVEL_MAX; fade_green = 8'd0;               end
    endcase
  end

  always_comb begin
    pressed       = !prev_q && lvl_q;
    prev_d        = lvl_q;
    el_inc        = elapsed_q + 16'd1;
    pat           = pattern_drive(phase_q);
    mode_d        = mode_q;
    elapsed_d     = elapsed_q;
    alarm_cnt_d   = alarm_cnt_q;
    phase_d       = phase_q;
    remind_done_d = remind_done_q;
    red_d         = red_q;
    green_d       = green_q;
    buzz_d        = (beep_q != 8'd0);
    beep_d        = (beep_q != 8'd0) ? beep_q - 8'd1 : beep_q;
    case (mode_q)
      MODE_IDLE: begin
        if (pressed) begin
          mode_d        = MODE_RUN;
          elapsed_d     = 16'd0;
          beep_d        = beep_len_q;
          remind_done_d = 1'b0;
        end
      end
      MODE_RUN: begin
        red_d     = fade_red;
        green_d   = fade_green;
        elapsed_d = el_inc;
        if (el_inc == remind_q && !remind_done_q) begin
          beep_d        = beep_len_q;
          remind_done_d = 1'b1;
        end
        if (pressed || el_inc >= turn_len_q) begin
          mode_d      = MODE_ALARM;
          alarm_cnt_d = 16'd0;
          phase_d     = 8'd0;
        end
      end
      MODE_ALARM: begin
        red_d   = fade_red;
        green_d = fade_green;
        if (pat.hit) buzz_d = pat.on;
        alarm_cnt_d = alarm_cnt_q + 16'd1;
        // phase tracks alarm count mod 240, restarting when the count wraps
        if (alarm_cnt_q == 16'hFFFF || phase_q == PHASE_LAST) begin
          phase_d = 8'd0;
        end else begin
          phase_d = phase_q + 8'd1;
        end
        if (pressed) begin
          mode_d        = MODE_IDLE;
          elapsed_d     = 16'd0;
          alarm_cnt_d   = 16'd0;
          phase_d       = 8'd0;
          remind_done_d = 1'b0;
          beep_d        = 8'd0;
          red_d         = 8'd0;
          green_d       = LEVEL_MAX;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_len_q    <= TURN_LEN_RST;
      remind_q      <= REMIND_RST;
      beep_len_q    <= BEEP_LEN_RST;
      state_q       <= ST_IDLE;
      div_cnt_q     <= 3'd0;
      mode_q        <= MODE_IDLE;
      elapsed_q     <= 16'd0;
      alarm_cnt_q   <= 16'd0;
      phase_q       <= 8'd0;
      prev_q        <= 1'b0;
      beep_q        <= 8'd0;
      remind_done_q <= 1'b0;
      red_q         <= 8'd0;
      green_q       <= LEVEL_MAX;
      buzz_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TURN_LEN: turn_len_q <= cfg_data_i;
          CFG_REMIND:   remind_q   <= cfg_data_i;
          CFG_BEEP_LEN: beep_len_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      state_q   <= state_d;
      div_cnt_q <= (state_q == ST_DIV && !div_last) ? div_cnt_q + 3'd1 : 3'd0;
      if (commit) begin
        mode_q        <= mode_d;
        elapsed_q     <= elapsed_d;
        alarm_cnt_q   <= alarm_cnt_d;
        phase_q       <= phase_d;
        prev_q        <= prev_d;
        beep_q        <= beep_d;
        remind_done_q <= remind_done_d;
        red_q         <= red_d;
        green_q       <= green_d;
        buzz_q        <= buzz_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign buzzer_on_o   = buzz_q;
  assign mode_o        = mode_q;

  // ---------------- checks ----------------
  a_div_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_DIV |-> div_cnt_q == 3'd0)
    else $error("divider step count active outside division");

  a_idle_colors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> (red_q == 8'd0 && green_q == LEVEL_MAX))
    else $error("idle mode must show plain green");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && seg_q != SEG_RED) |-> rem_q < {8'd0, turn_len_q[15:2]})
    else $error("divider remainder not below quarter");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PHASE_LAST)
    else $error("alarm phase beyond pattern period");

endmodule

### test/turn_timer_fade_alarm_tb.sv
`timescale 1ns / 100ps

module turn_timer_fade_alarm_tb;
  import ttfa_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int REPORT_MAX = 10;
  localparam int PATTERN_PERIOD = 240;
  localparam int PAT_ON [6] = '{5, 5, 10, 5, 5, 10};
  localparam int PAT_OFF [6] = '{5, 5, 10, 5, 5, 20};
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic       buzz;
    mode_e      mode;
  } lamp_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        button_level_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  red_level_o;
  logic [7:0]  green_level_o;
  logic        buzzer_on_o;
  logic [1:0]  mode_o;

  turn_timer_fade_alarm u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .button_level_i (button_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_level_o    (red_level_o),
    .green_level_o  (green_level_o),
    .buzzer_on_o    (buzzer_on_o),
    .mode_o         (mode_o)
  );

  always #5 clk_i = ~clk_i;

  // timer state as the block should hold it
  logic [15:0] cfg_turn_len;
  logic [15:0] cfg_remind_at;
  logic [7:0]  cfg_beep_len;
  mode_e       ctl_mode;
  logic [15:0] tick_count;
  logic [15:0] alarm_ticks;
  logic [7:0]  beep_left;
  logic        reminder_fired;
  logic        prev_level;
  logic [7:0]  lamp_red;
  logic [7:0]  lamp_green;

  lamp_state_t expected_lamps[$];
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int items_sent = 0;
  int results_checked = 0;
  int lamp_errors = 0;
  int alarm_entries = 0;
  int reminder_beeps = 0;
  int unsigned cycles = 0;

  task automatic restore_defaults();
    cfg_turn_len = TURN_LEN_RST;
    cfg_remind_at = REMIND_RST;
    cfg_beep_len = BEEP_LEN_RST;
    ctl_mode = MODE_IDLE;
    tick_count = '0;
    alarm_ticks = '0;
    beep_left = '0;
    reminder_fired = 1'b0;
    prev_level = 1'b0;
    lamp_red = 8'd0;
    lamp_green = 8'd255;
  endtask

  function automatic void update_fade();
    int quarter;
    int e;
    quarter = cfg_turn_len >> 2;
    e = tick_count;
    // quarter of zero falls through to full red without dividing
    if (e < quarter) begin
      lamp_red = 8'((e * 255) / quarter);
      lamp_green = 8'd255;
    end else if (e < 2 * quarter) begin
      lamp_red = 8'd255;
      lamp_green = 8'(255 - ((e - quarter) * 90) / quarter);
    end else if (e < 3 * quarter) begin
      lamp_red = 8'd255;
      lamp_green = 8'(165 - ((e - 2 * quarter) * 165) / quarter);
    end else begin
      lamp_red = 8'd255;
      lamp_green = 8'd0;
    end
  endfunction

  // 1 sound, 0 silence, -1 past the pattern
  function automatic int buzzer_pattern(input logic [15:0] count);
    int phase;
    phase = int'(count) % PATTERN_PERIOD;
    for (int i = 0; i < 6; i++) begin
      if (phase < PAT_ON[i]) return 1;
      phase -= PAT_ON[i];
      if (phase < PAT_OFF[i]) return 0;
      phase -= PAT_OFF[i];
    end
    return -1;
  endfunction

  function automatic lamp_state_t predict_tick(input logic level);
    lamp_state_t res;
    logic pressed;
    logic buzz;
    int drive;
    pressed = !prev_level && level;
    prev_level = level;
    buzz = 1'b0;
    if (beep_left != 0) begin
      buzz = 1'b1;
      beep_left--;
    end
    case (ctl_mode)
      MODE_IDLE: begin
        if (pressed) begin
          ctl_mode = MODE_RUN;
          tick_count = '0;
          beep_left = cfg_beep_len;
          reminder_fired = 1'b0;
        end
      end
      MODE_RUN: begin
        update_fade();
        tick_count++;
        if (tick_count == cfg_remind_at && !reminder_fired) begin
          beep_left = cfg_beep_len;
          reminder_fired = 1'b1;
          reminder_beeps++;
        end
        if (pressed || tick_count >= cfg_turn_len) begin
          ctl_mode = MODE_ALARM;
          alarm_ticks = '0;
          alarm_entries++;
        end
      end
      MODE_ALARM: begin
        update_fade();
        drive = buzzer_pattern(alarm_ticks);
        if (drive >= 0) buzz = drive[0];
        alarm_ticks++;
        if (pressed) begin
          ctl_mode = MODE_IDLE;
          tick_count = '0;
          alarm_ticks = '0;
          reminder_fired = 1'b0;
          beep_left = '0;
          lamp_red = 8'd0;
          lamp_green = 8'd255;
        end
      end
      default: ;
    endcase
    res.red = lamp_red;
    res.green = lamp_green;
    res.buzz = buzz;
    res.mode = ctl_mode;
    return res;
  endfunction

  // leaves valid high on return; the next call keeps it or drops it
  task automatic send_tick(input logic level);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      button_level_i = 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    button_level_i = level;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_lamps.push_back(predict_tick(level));
    items_sent++;
  endtask

  task automatic press_button();
    repeat ($urandom_range(1, 3)) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_lamps.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_TURN_LEN: cfg_turn_len = value;
      CFG_REMIND:   cfg_remind_at = value;
      CFG_BEEP_LEN: cfg_beep_len = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_timer(input int turn, input int remind, input int beep);
    wait_idle();
    write_reg(CFG_TURN_LEN, 16'(turn));
    write_reg(CFG_REMIND, 16'(remind));
    write_reg(CFG_BEEP_LEN, 16'(beep));
  endtask

  task automatic send_levels(input logic [31:0] levels, input int count);
    for (int i = count - 1; i >= 0; i--) send_tick(levels[i]);
  endtask

  // reset values: start, press to alarm, press back to idle
  task automatic test_default_turn();
    send_levels(32'b101010, 6);
  endtask

  // quarter of 2: every fade segment, reminder at 5, timeout at 8
  task automatic test_fade_segments();
    set_timer(8, 5, 2);
    send_levels(32'b1000000000_10, 12);
  endtask

  // zero beep length, reminder at zero, write to the unused index
  task automatic test_quiet_beeps();
    set_timer(4, 0, 0);
    write_reg(CFG_IDX_UNUSED, 16'hffff);
    send_levels(32'b1000010, 7);
  endtask

  // turn of 3 gives a zero quarter; reminder past the turn; longest beep
  task automatic test_short_turn();
    set_timer(3, 9, 255);
    send_levels(32'b1000010, 7);
  endtask

  task automatic test_register_extremes();
    set_timer(65535, 65535, 255);
    send_levels(32'b1010100, 7);
    set_timer(65535, 1, 1);
    send_levels(32'b10010, 5);
  endtask

  // sit in alarm through a whole buzzer period, including the silent gap
  task automatic test_alarm_period();
    set_timer(4, 2, 3);
    send_tick(1'b1);
    repeat (250) send_tick(1'b0);
    send_levels(32'b10, 2);
  endtask

  task automatic pick_random_timer();
    int r;
    int turn;
    int remind;
    int beep;
    r = $urandom_range(9);
    if (r < 6) turn = $urandom_range(4, 48);
    else if (r < 8) turn = $urandom_range(49, 400);
    else if (r == 8) turn = $urandom_range(0, 3);
    else turn = $urandom_range(401, 65535);
    remind = $urandom_range(0, turn + 4);
    if (remind > 65535) remind = 65535;
    beep = ($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    set_timer(turn, remind, beep);
    if ($urandom_range(3) == 0) write_reg(CFG_IDX_UNUSED, 16'($urandom));
  endtask

  // mostly complete turns steered by the tracked mode, some noise bursts
  task automatic play_turns(input int n_items);
    int start;
    int room;
    int n;
    int left;
    start = items_sent;
    while (items_sent - start < n_items) begin
      left = n_items - (items_sent - start);
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)));
        send_tick(1'b0);
      end else begin
        case (ctl_mode)
          MODE_RUN: begin
            room = int'(cfg_turn_len) - int'(tick_count) + 2;
            if (room > 60) room = 60;
            if (room > left) room = left;
            if (room < 0) room = 0;
            repeat ($urandom_range(0, room)) send_tick(1'b0);
            if ($urandom_range(1)) press_button();
          end
          MODE_ALARM: begin
            n = ($urandom_range(3) == 0) ? $urandom_range(90, 250) : $urandom_range(0, 30);
            if (n > left) n = left;
            repeat (n) send_tick(1'b0);
            press_button();
          end
          default: press_button();
        endcase
      end
    end
  endtask

  task automatic test_random_turns(input int tx_pct, input int rx_pct, input int n_items);
    wait_idle();
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (3) begin
      pick_random_timer();
      play_turns(n_items / 3);
    end
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_stall_pct);

  always @(posedge clk_i) begin : result_check
    lamp_state_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (expected_lamps.size() == 0) begin
        lamp_errors++;
        if (lamp_errors <= REPORT_MAX)
          $display("unexpected result: red %0d green %0d buzz %0d mode %0d",
                   red_level_o, green_level_o, buzzer_on_o, mode_o);
      end else begin
        want = expected_lamps.pop_front();
        if (red_level_o !== want.red || green_level_o !== want.green ||
            buzzer_on_o !== want.buzz || mode_o !== want.mode) begin
          lamp_errors++;
          if (lamp_errors <= REPORT_MAX)
            $display("result %0d: expected red %0d green %0d buzz %0d mode %0d, %s",
                     results_checked, want.red, want.green, want.buzz, want.mode,
                     $sformatf("got red %0d green %0d buzz %0d mode %0d",
                               red_level_o, green_level_o, buzzer_on_o, mode_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_lamps.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TURN_LEN;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    button_level_i = 1'b0;
    restore_defaults();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_turn();
    test_fade_segments();
    test_quiet_beeps();
    test_short_turn();
    test_register_extremes();
    test_alarm_period();
    test_random_turns(0, 0, 60);
    test_random_turns(63, 0, 60);
    test_random_turns(0, 63, 60);
    test_random_turns(16, 16, 60);
    wait_idle();

    $display("%0d ticks over reset, fade, short-turn, extreme and random timer settings,",
             items_sent);
    $display("%0d results checked, %0d alarms, %0d reminders",
             results_checked, alarm_entries, reminder_beeps);
    if (lamp_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatching results", lamp_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
